>>> design/lbpdh_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and a helper function of the LBP direction histogram unit.
package lbpdh_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W    = 8;
  localparam int SIZE_W   = 11;
  localparam int CNT_W    = 20;
  localparam int NUM_DIR  = 8;
  localparam int MIN_SIZE = 3;
  localparam int BORDER   = 2;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  localparam int SPAN_A = $clog2(MAX_WIDTH + 1);
  localparam int SPAN_B = $clog2(MAX_HEIGHT + 1);
  localparam int SPAN_AB = (SPAN_A > SPAN_B) ? SPAN_A : SPAN_B;
  localparam int SPAN_W = (SPAN_AB > SIZE_W) ? SPAN_AB : SIZE_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int OUT_DATA_W = NUM_DIR * CNT_W;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;
  typedef logic [NUM_DIR-1:0][CNT_W-1:0] counts_t;

  typedef struct packed {
    logic valid;
    logic count_en;
    logic last;
  } item_ctrl_t;

  function automatic logic [SPAN_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SPAN_W-1:0] maxv);
    logic [SPAN_W-1:0] vx;
    vx = SPAN_W'(v);
    if (vx < SPAN_W'(MIN_SIZE)) begin
      return SPAN_W'(MIN_SIZE);
    end else if (vx > maxv) begin
      return maxv;
    end
    return vx;
  endfunction

endpackage

>>> design/lbpdh_line_store.sv
`timescale 1ns / 1ps
// Two-row line store memory with read-modify-write and the 3x3 neighbourhood window.
module lbpdh_line_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [lbpdh_pkg::COL_W-1:0]    rd_addr,
  input  lbpdh_pkg::pix_t                pixel,
  input  lbpdh_pkg::item_ctrl_t          ctrl_in,
  output lbpdh_pkg::win_t                win,
  output lbpdh_pkg::item_ctrl_t          ctrl_out
);
  import lbpdh_pkg::*;

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;

  item_ctrl_t         s1_ctrl_r;
  logic [COL_W-1:0]   s1_col_r;
  pix_t               s1_px_r;
  win_t               win_r;
  item_ctrl_t         s2_ctrl_r;
  pix_t               top_px;
  pix_t               mid_px;

  assign top_px = rd_data_r[2*PIX_W-1:PIX_W];
  assign mid_px = rd_data_r[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (s1_ctrl_r.valid) begin
      mem[s1_col_r] <= {mid_px, s1_px_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
      s2_ctrl_r <= '0;
      win_r     <= '0;
    end else begin
      s1_ctrl_r <= rd_en ? ctrl_in : '0;
      s2_ctrl_r <= s1_ctrl_r;
      if (s1_ctrl_r.valid) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= top_px;
        win_r[1][2] <= mid_px;
        win_r[2][2] <= s1_px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_col_r <= rd_addr;
      s1_px_r  <= pixel;
    end
  end

  assign win      = win_r;
  assign ctrl_out = s2_ctrl_r;

  a_no_same_entry_clash: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && s1_ctrl_r.valid |-> rd_addr != s1_col_r)
    else $error("line store read and write hit the same entry in one cycle");

endmodule

>>> design/lbpdh_counter.sv
`timescale 1ns / 1ps
// Eight direction comparators, the direction counters and the result register.
module lbpdh_counter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lbpdh_pkg::win_t                   win,
  input  lbpdh_pkg::item_ctrl_t             ctrl,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lbpdh_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import lbpdh_pkg::*;

  counts_t            cnt_r;
  counts_t            cnt_nxt;
  counts_t            out_cnt_r;
  logic               out_valid_r;
  pix_t               centre;
  pix_t [NUM_DIR-1:0] nb;
  logic [NUM_DIR-1:0] inc;

  assign centre = win[1][1];
  assign nb[0]  = win[0][0];
  assign nb[1]  = win[0][1];
  assign nb[2]  = win[0][2];
  assign nb[3]  = win[1][0];
  assign nb[4]  = win[1][2];
  assign nb[5]  = win[2][0];
  assign nb[6]  = win[2][1];
  assign nb[7]  = win[2][2];

  always_comb begin
    for (int k = 0; k < NUM_DIR; k++) begin
      inc[k]     = ctrl.valid && ctrl.count_en && (nb[k] >= centre);
      cnt_nxt[k] = cnt_r[k] + CNT_W'(inc[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.valid && ctrl.last) begin
        cnt_r       <= '0;
        out_valid_r <= 1'b1;
      end else begin
        cnt_r <= cnt_nxt;
        if (out_tready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid && ctrl.last) begin
      out_cnt_r <= cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_cnt_r;

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.valid && ctrl.last |-> !(out_valid_r && !out_tready))
    else $error("frame result arrived while the previous result was still held");

  a_counts_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.valid && ctrl.last |=> cnt_r == '0)
    else $error("direction counters not cleared after a frame result");

endmodule

>>> design/lbp_direction_histogram_unit.sv
`timescale 1ns / 1ps
// Top level of the LBP direction histogram unit: configuration, raster position and flow control.
//
//  Channel | Direction | Word
//  in_     | input     | one 8-bit gray pixel, raster order
//  out_    | output    | eight 20-bit direction counts, one word per frame
//  cfg_    | register  | frame_width at 0x0, frame_height at 0x4
//
// One pixel is accepted in every cycle, but for the stall named below; a line store memory with
// one read and one write port per cycle sets that rate. The frame result passes the line
// store's input stage, the window register and the counter's result register on its way to
// the output. Reset clears the position, the counters and the window; the line store is not
// cleared. Only the frame's last pixel waits while an earlier result is still held at the output.
module lbp_direction_histogram_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // pixel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // count_up_left, count_up, count_up_right, count_left, count_right,
  // count_down_left, count_down, count_down_right
  output logic [lbpdh_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [lbpdh_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [lbpdh_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [lbpdh_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                 cfg_pready
);
  import lbpdh_pkg::*;

  logic [SIZE_W-1:0] cfg_width_r;
  logic [SIZE_W-1:0] cfg_height_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [SPAN_W-1:0] width_eff;
  logic [SPAN_W-1:0] height_eff;
  logic              row_end;
  logic              frame_end;
  logic              in_accept;
  logic              out_busy;
  logic              cfg_write;
  reg_index_t        cfg_idx;
  item_ctrl_t        in_ctrl;
  item_ctrl_t        win_ctrl;
  win_t              win;
  pix_t              pixel;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_index_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RESET;
      cfg_height_r <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  cfg_width_r  <= cfg_pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: cfg_height_r <= cfg_pwdata[SIZE_W-1:0];
        default:          cfg_width_r  <= cfg_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  cfg_prdata = CFG_DATA_W'(cfg_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DATA_W'(cfg_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign width_eff  = clamp_size(cfg_width_r, SPAN_W'(MAX_WIDTH));
  assign height_eff = clamp_size(cfg_height_r, SPAN_W'(MAX_HEIGHT));

  assign row_end   = (SPAN_W'(col_r) + SPAN_W'(1)) >= width_eff;
  assign frame_end = row_end && ((SPAN_W'(row_r) + SPAN_W'(1)) >= height_eff);

  assign out_busy  = out_tvalid && !out_tready;
  assign in_tready = !(out_busy && frame_end);
  assign in_accept = in_tvalid && in_tready;
  assign pixel     = in_tdata[PIX_W-1:0];

  assign in_ctrl.valid    = 1'b1;
  assign in_ctrl.count_en = (row_r >= ROW_W'(BORDER)) && (col_r >= COL_W'(BORDER));
  assign in_ctrl.last     = frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= frame_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  lbpdh_line_store u_line_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd_addr  (col_r),
    .pixel    (pixel),
    .ctrl_in  (in_ctrl),
    .win      (win),
    .ctrl_out (win_ctrl)
  );

  lbpdh_counter u_counter (
    .clk        (clk),
    .rst_n      (rst_n),
    .win        (win),
    .ctrl       (win_ctrl),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> dv/lbpdh_checker.sv
`timescale 1ns / 1ps
// Checker for the LBP direction histogram unit: tracks registers, predicts frame counts, compares.
module lbpdh_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // pixel
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // count_up_left, count_up, count_up_right, count_left, count_right,
  // count_down_left, count_down, count_down_right
  input  logic [lbpdh_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [lbpdh_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [lbpdh_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [lbpdh_pkg::CFG_DATA_W-1:0] cfg_prdata,
  input  logic                             cfg_pready,
  output int                               errors,
  output int                               pending
);
  import lbpdh_pkg::*;

  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  pix_t              line_older [MAX_WIDTH];
  pix_t              line_newer [MAX_WIDTH];
  win_t              win;
  int                col_pos;
  int                row_pos;
  counts_t           tally;
  counts_t           frame_counts_q [$];

  function automatic int size_limit(input logic [SIZE_W-1:0] raw, input int maxv);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (int'(raw) > maxv) return maxv;
    return int'(raw);
  endfunction

  function automatic string dir_name(input int d);
    case (d)
      0: return "count_up_left";
      1: return "count_up";
      2: return "count_up_right";
      3: return "count_left";
      4: return "count_right";
      5: return "count_down_left";
      6: return "count_down";
      default: return "count_down_right";
    endcase
  endfunction

  task automatic absorb_pixel(input pix_t px);
    int   w;
    int   h;
    pix_t top;
    pix_t mid;
    pix_t centre;
    pix_t nb [NUM_DIR];
    w = size_limit(width_reg, MAX_WIDTH);
    h = size_limit(height_reg, MAX_HEIGHT);
    top = line_older[col_pos];
    mid = line_newer[col_pos];
    line_older[col_pos] = mid;
    line_newer[col_pos] = px;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    if (row_pos >= BORDER && col_pos >= BORDER) begin
      centre = win[1][1];
      nb[0] = win[0][0];
      nb[1] = win[0][1];
      nb[2] = win[0][2];
      nb[3] = win[1][0];
      nb[4] = win[1][2];
      nb[5] = win[2][0];
      nb[6] = win[2][1];
      nb[7] = win[2][2];
      for (int d = 0; d < NUM_DIR; d++) begin
        if (nb[d] >= centre) tally[d] = tally[d] + 1'b1;
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        frame_counts_q = {frame_counts_q, tally};
        tally = '0;
        row_pos = 0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endtask

  task automatic check_result(input counts_t got);
    counts_t want;
    if (frame_counts_q.size() == 0) begin
      $error("Result word with no frame outstanding: %h", got);
      errors++;
    end else begin
      want = frame_counts_q.pop_front();
      for (int d = 0; d < NUM_DIR; d++) begin
        if (got[d] !== want[d]) begin
          $error("%s: expected %0d, got %0d", dir_name(d), want[d], got[d]);
          errors++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      win = '0;
      col_pos = 0;
      row_pos = 0;
      tally = '0;
      frame_counts_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr == {REG_FRAME_WIDTH, 2'b00}) begin
            width_reg = cfg_pwdata[SIZE_W-1:0];
          end else if (cfg_paddr == {REG_FRAME_HEIGHT, 2'b00}) begin
            height_reg = cfg_pwdata[SIZE_W-1:0];
          end
        end else if (cfg_paddr == {REG_FRAME_WIDTH, 2'b00}) begin
          if (cfg_prdata !== CFG_DATA_W'(width_reg)) begin
            $error("frame_width: expected %0d, got %0d", width_reg, cfg_prdata);
            errors++;
          end
        end else if (cfg_paddr == {REG_FRAME_HEIGHT, 2'b00}) begin
          if (cfg_prdata !== CFG_DATA_W'(height_reg)) begin
            $error("frame_height: expected %0d, got %0d", height_reg, cfg_prdata);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) absorb_pixel(in_tdata);
      if (out_tvalid && out_tready) check_result(out_tdata);
      pending = frame_counts_q.size();
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the LBP direction histogram unit: clock, reset, stimulus and verdict.
module tb_top;
  import lbpdh_pkg::*;

  typedef enum int {
    PIX_UNIFORM,
    PIX_NEAR,
    PIX_RAILS,
    PIX_FLAT
  } pix_style_t;

  // Three 3x3 frames: a bright centre, ties around a mid-grey centre, a dark centre.
  localparam logic [7:0] DIRECTED_PX [0:26] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
    8'd127, 8'd128, 8'd129, 8'd129, 8'd128, 8'd127, 8'd0,   8'd128, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // pixel
  logic                  out_tvalid;
  logic                  out_tready;
  // count_up_left, count_up, count_up_right, count_left, count_right,
  // count_down_left, count_down, count_down_right
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int errors;
  int pending;
  bit in_steady;
  bit out_steady;
  int cur_w;
  int cur_h;
  int px_total;
  int frame_total;
  int setting_total;

  lbp_direction_histogram_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  lbpdh_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int eff_dim(input logic [SIZE_W-1:0] raw, input int maxv);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (int'(raw) > maxv) return maxv;
    return int'(raw);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return SIZE_W'($urandom_range(0, 2));
    if (r == 1) return SIZE_W'($urandom_range(8, 24));
    return SIZE_W'($urandom_range(3, 6));
  endfunction

  task automatic reg_access(input reg_index_t idx, input bit wr, input logic [SIZE_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {(CFG_DATA_W - SIZE_W)'($urandom()), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] w_raw, input logic [SIZE_W-1:0] h_raw);
    reg_access(REG_FRAME_WIDTH, 1'b1, w_raw);
    reg_access(REG_FRAME_HEIGHT, 1'b1, h_raw);
    reg_access(REG_FRAME_WIDTH, 1'b0, '0);
    reg_access(REG_FRAME_HEIGHT, 1'b0, '0);
    cur_w = eff_dim(w_raw, MAX_WIDTH);
    cur_h = eff_dim(h_raw, MAX_HEIGHT);
    setting_total++;
  endtask

  task automatic push_pixel(input logic [7:0] pix);
    int gap;
    gap = in_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    do @(posedge clk); while (!in_tready);
    px_total++;
  endtask

  task automatic send_frame(input pix_style_t style);
    int base;
    int v;
    base = $urandom_range(0, 255);
    for (int i = 0; i < cur_w * cur_h; i++) begin
      case (style)
        PIX_UNIFORM: begin
          v = $urandom_range(0, 255);
        end
        PIX_NEAR: begin
          v = base + $urandom_range(0, 4) - 2;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
        end
        PIX_RAILS: begin
          v = ($urandom_range(0, 1) == 1) ? 255 : 0;
        end
        default: begin
          v = base;
        end
      endcase
      push_pixel(8'(v));
    end
    frame_total++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    int style_pick;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_steady = 1'b0;
    out_steady = 1'b0;
    px_total = 0;
    frame_total = 0;
    setting_total = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values read back first, then undersized registers that act as 3x3.
    reg_access(REG_FRAME_WIDTH, 1'b0, '0);
    reg_access(REG_FRAME_HEIGHT, 1'b0, '0);
    set_size(SIZE_W'(0), SIZE_W'(2));
    for (int i = 0; i < 27; i++) push_pixel(DIRECTED_PX[i]);
    frame_total += 3;
    drain();

    while (px_total < 620) begin
      in_steady = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      set_size(pick_dim(), pick_dim());
      repeat ($urandom_range(1, 3)) begin
        style_pick = $urandom_range(0, 9);
        if (style_pick < 5) send_frame(PIX_UNIFORM);
        else if (style_pick < 7) send_frame(PIX_NEAR);
        else if (style_pick < 9) send_frame(PIX_RAILS);
        else send_frame(PIX_FLAT);
      end
      drain();
    end

    $display("Run covered %0d pixels in %0d frames over %0d frame size settings,",
             px_total, frame_total, setting_total);
    $display("from 3x3 up to 24x24, with undersized register values acting as three.");
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      stall = out_steady ? 0 : idle_len();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    #(20ms);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
